[hdl/separable_gaussian_blur_defines.svh]
// Assertion macros for the blur RTL.
// No dependencies; files that check their own logic include this header.
`ifndef SEPARABLE_GAUSSIAN_BLUR_DEFINES_SVH
`define SEPARABLE_GAUSSIAN_BLUR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SGB_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("blur check failed");

// The consequent must hold in the cycle after the antecedent.
`define SGB_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("blur check failed");

`endif

[hdl/sgb_pkg.sv]
// Shared constants, payload structs and configuration struct of the blur block.
// No dependencies.
`timescale 1ns / 1ps
package sgb_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_RADIUS  = 4;
   localparam int RADIUS_CAP  = (MAX_RADIUS < 4) ? MAX_RADIUS : 4;
   localparam int SLOTS       = 2 * MAX_RADIUS + 1;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int STORE_DEPTH = SLOTS * MAX_WIDTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int WEFF_W      = $clog2(MAX_WIDTH + 1);

   localparam int FW_W        = 11;
   localparam int ROW_W       = 12;
   localparam int RAD_W       = 3;
   localparam int WT_W        = 16;
   localparam int PIX_W       = 8;
   localparam int HSUM_W      = 24;
   localparam int NUM_WEIGHTS = 5;
   localparam int WIN_DEPTH   = 9;
   localparam int CSR_IDX_W   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_RADIUS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_CENTER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_ONE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_TWO    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_THREE  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_FOUR   = 3'd7;

   localparam logic [FW_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
   localparam logic [ROW_W-1:0] RST_FRAME_HEIGHT = 12'd480;
   localparam logic [RAD_W-1:0] RST_RADIUS       = 3'd1;
   localparam logic [WT_W-1:0]  RST_WEIGHT_CENTER = 16'd32768;
   localparam logic [WT_W-1:0]  RST_WEIGHT_ONE    = 16'd16384;

   typedef struct packed {
      logic             mode;
      logic [PIX_W-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             row_end;
      logic             frame_end;
      logic             run_last;
   } rsp_type;

   typedef struct packed {
      logic [FW_W-1:0]                       frame_width;
      logic [ROW_W-1:0]                      frame_height;
      logic [RAD_W-1:0]                      kernel_radius;
      logic [NUM_WEIGHTS-1:0][WT_W-1:0]      weight;
   } cfg_type;

endpackage

[hdl/sgb_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module sgb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 9216
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[hdl/sgb_out_buf.sv]
// Output register of the blur block: holds one result item until it is taken.
// Depends on sgb_pkg.
`timescale 1ns / 1ps
module sgb_out_buf (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  sgb_pkg::rsp_type push_data,
   output logic            push_ready,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output sgb_pkg::rsp_type rsp_data
);
   import sgb_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign push_ready = !valid_ff || !rsp_stall;
   assign valid_in   = push || (valid_ff && rsp_stall);
   assign rsp_valid  = valid_ff;
   assign rsp_data   = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && push_ready) begin
         data_ff <= push_data;
      end
   end

endmodule

[hdl/sgb_engine.sv]
// Sequencer and datapath of the blur: row window, horizontal taps, line store
// writes and reads, and vertical taps. Depends on sgb_pkg, sgb_ram and the defines header.
`timescale 1ns / 1ps
`include "separable_gaussian_blur_defines.svh"
module sgb_engine (
   input  logic             clock,
   input  logic             reset,
   input  sgb_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  sgb_pkg::req_type req_data,
   output logic             res_valid,
   input  logic             res_ready,
   output sgb_pkg::rsp_type res_data
);
   import sgb_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_HSUM  = 3'd1;
   localparam logic [2:0] S_WRITE = 3'd2;
   localparam logic [2:0] S_VSUM  = 3'd3;
   localparam logic [2:0] S_VWAIT = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W     = 21;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + SLOTS - 1) / SLOTS;
   localparam int HACC_W      = 28;
   localparam int PROD_W      = HSUM_W + WT_W;
   localparam int VACC_W      = PROD_W + 5;
   localparam int Q_W         = ROW_W + 2;

   // Row modulo the slot count, by a reciprocal multiply; exact for 12-bit rows.
   function automatic logic [SLOT_W-1:0] slot_of(input logic [ROW_W-1:0] row);
      logic [ROW_W+RECIP_W-1:0] p;
      logic [ROW_W-1:0]         quo;
      logic [ROW_W-1:0]         rem;
      p   = (ROW_W+RECIP_W)'(row) * (ROW_W+RECIP_W)'(RECIP);
      quo = ROW_W'(p >> RECIP_SHIFT);
      rem = row - ROW_W'(quo * ROW_W'(SLOTS));
      return SLOT_W'(rem);
   endfunction

   function automatic logic [ROW_W-1:0] clamp_row(input logic signed [Q_W-1:0] q,
                                                  input logic [ROW_W-1:0] h);
      logic signed [Q_W-1:0] top;
      top = $signed({2'b00, h}) - $signed(Q_W'(1));
      if (q < 0) begin
         return '0;
      end else if (q > top) begin
         return h - ROW_W'(1);
      end
      return q[ROW_W-1:0];
   endfunction

   function automatic logic [2:0] wsel(input logic [3:0] t, input logic [RAD_W-1:0] r);
      logic [3:0] rr;
      rr = {1'b0, r};
      return (t >= rr) ? 3'(t - rr) : 3'(rr - t);
   endfunction

   // Effective configuration.
   logic [WEFF_W-1:0] w_eff;
   logic [ROW_W-1:0]  h_eff;
   logic [RAD_W-1:0]  r_eff;

   always_comb begin
      if (cfg.frame_width == '0) begin
         w_eff = WEFF_W'(1);
      end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
         w_eff = WEFF_W'(MAX_WIDTH);
      end else begin
         w_eff = WEFF_W'(cfg.frame_width);
      end
      h_eff = (cfg.frame_height == '0) ? ROW_W'(1) : cfg.frame_height;
      if (cfg.kernel_radius == '0) begin
         r_eff = RAD_W'(1);
      end else if (32'(cfg.kernel_radius) > RADIUS_CAP) begin
         r_eff = RAD_W'(RADIUS_CAP);
      end else begin
         r_eff = cfg.kernel_radius;
      end
   end

   logic [2:0]                      state_ff, state_in;
   logic [3:0]                      t_ff, t_in;
   logic [HACC_W-1:0]               acc_h_ff, acc_h_in;
   logic [COL_W-1:0]                c_ff, c_in, hi_ff, hi_in, col_ff, col_in;
   logic                            emit_ff, emit_in, drain_ff, drain_in;
   logic                            rowend_ff, rowend_in, re_ff, re_in, fe_ff, fe_in;
   logic [ROW_W-1:0]                oy_ff, oy_in;
   logic [SLOT_W-1:0]               wslot_ff, wslot_in;
   logic signed [Q_W-1:0]           q_ff, q_in;
   logic [ROW_W-1:0]                yyc_ff, yyc_in;
   logic [VACC_W-1:0]               acc_v_ff, acc_v_in;
   logic [WIN_DEPTH-1:0][PIX_W-1:0] win_ff, win_in;
   logic [COL_W-1:0]                in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0]                in_row_ff, in_row_in, out_row_ff, out_row_in;

   logic                 rd_v_ff;
   logic [2:0]           rd_ws_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic                 prod_v_ff;

   logic                 mem_we, mem_re;
   logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
   logic [HSUM_W-1:0]    mem_wdata, mem_rdata;
   logic [2:0]           ws_now;
   logic [3:0]           last_tap;

   logic [VACC_W:0]      rnd;
   logic [VACC_W-32:0]   vshift;

   assign last_tap  = {r_eff, 1'b0};
   assign ws_now    = wsel(t_ff, r_eff);
   assign req_stall = (state_ff != S_IDLE);

   assign mem_waddr = ADDR_W'(wslot_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c_ff);
   assign mem_wdata = (acc_h_ff > HACC_W'({HSUM_W{1'b1}})) ? {HSUM_W{1'b1}}
                                                         : acc_h_ff[HSUM_W-1:0];
   assign mem_raddr = ADDR_W'(slot_of(yyc_ff)) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c_ff);

   // Round half up at bit 32, then saturate.
   assign rnd    = {1'b0, acc_v_ff} + (VACC_W+1)'(64'h8000_0000);
   assign vshift = rnd[VACC_W:32];

   always_comb begin
      res_data.pixel_out = (|vshift[VACC_W-32:PIX_W]) ? {PIX_W{1'b1}} : vshift[PIX_W-1:0];
      res_data.row_end   = drain_ff ? re_ff : (rowend_ff && (c_ff == col_ff));
      res_data.frame_end = drain_ff && fe_ff;
      res_data.run_last  = drain_ff || (c_ff == hi_ff);
   end

   always_comb begin
      logic [COL_W-1:0]     col;
      logic                 rowend_now;
      logic [2:0]           j;
      logic signed [5:0]    kk;
      logic [3:0]           widx;
      logic [HSUM_W-1:0]    ph;
      logic signed [Q_W-1:0] qn;

      state_in   = state_ff;
      t_in       = t_ff;
      acc_h_in   = acc_h_ff;
      c_in       = c_ff;
      hi_in      = hi_ff;
      col_in     = col_ff;
      emit_in    = emit_ff;
      drain_in   = drain_ff;
      rowend_in  = rowend_ff;
      re_in      = re_ff;
      fe_in      = fe_ff;
      oy_in      = oy_ff;
      wslot_in   = wslot_ff;
      q_in       = q_ff;
      yyc_in     = yyc_ff;
      acc_v_in   = prod_v_ff ? acc_v_ff + VACC_W'(prod_ff) : acc_v_ff;
      win_in     = win_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      res_valid  = 1'b0;

      col        = in_col_ff;
      rowend_now = (32'(in_col_ff) + 32'd1) >= 32'(w_eff);
      j          = 3'(col_ff - c_ff);
      kk         = $signed({3'b000, j}) + $signed({3'b000, r_eff}) - $signed({2'b00, t_ff});
      widx       = (kk < 0) ? 4'd0 : 4'(kk);
      ph         = HSUM_W'(cfg.weight[ws_now]) * HSUM_W'(win_ff[widx]);
      qn         = q_ff + $signed(Q_W'(1));

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (!req_data.mode) begin
                  if (in_row_ff < h_eff) begin
                     if (col == '0) begin
                        for (int k = 0; k < WIN_DEPTH; k++) begin
                           win_in[k] = req_data.pixel_in;
                        end
                     end else begin
                        for (int k = WIN_DEPTH - 1; k > 0; k--) begin
                           win_in[k] = win_ff[k-1];
                        end
                        win_in[0] = req_data.pixel_in;
                     end
                     col_in    = col;
                     rowend_in = rowend_now;
                     drain_in  = 1'b0;
                     wslot_in  = slot_of(in_row_ff);
                     oy_in     = in_row_ff - ROW_W'(r_eff);
                     emit_in   = in_row_ff >= ROW_W'(r_eff);
                     t_in      = '0;
                     acc_h_in  = '0;
                     if (rowend_now) begin
                        c_in     = (col >= COL_W'(r_eff)) ? col - COL_W'(r_eff) : '0;
                        hi_in    = col;
                        state_in = S_HSUM;
                     end else if (col >= COL_W'(r_eff)) begin
                        c_in     = col - COL_W'(r_eff);
                        hi_in    = col - COL_W'(r_eff);
                        state_in = S_HSUM;
                     end
                     if (rowend_now) begin
                        in_col_in = '0;
                        in_row_in = in_row_ff + ROW_W'(1);
                     end else begin
                        in_col_in = col + COL_W'(1);
                     end
                  end
               end else if (in_row_ff >= h_eff) begin
                  // A drain tick releases one pending pixel of the bottom rows.
                  drain_in = 1'b1;
                  c_in     = out_col_ff;
                  oy_in    = out_row_ff;
                  re_in    = (32'(out_col_ff) + 32'd1) >= 32'(w_eff);
                  fe_in    = ((32'(out_col_ff) + 32'd1) >= 32'(w_eff)) &&
                             ((32'(out_row_ff) + 32'd1) >= 32'(h_eff));
                  t_in     = '0;
                  q_in     = $signed({2'b00, out_row_ff}) - $signed(Q_W'(r_eff));
                  yyc_in   = clamp_row($signed({2'b00, out_row_ff}) - $signed(Q_W'(r_eff)),
                                       h_eff);
                  acc_v_in = '0;
                  state_in = S_VSUM;
               end
            end
         end
         S_HSUM: begin
            acc_h_in = acc_h_ff + HACC_W'(ph);
            if (t_ff == last_tap) begin
               state_in = S_WRITE;
            end else begin
               t_in = t_ff + 4'd1;
            end
         end
         S_WRITE: begin
            // The sum is written here; the vertical reads start in the next cycle,
            // so a read of this entry always sees the new value.
            mem_we = 1'b1;
            t_in   = '0;
            if (emit_ff) begin
               q_in     = $signed({2'b00, oy_ff}) - $signed(Q_W'(r_eff));
               yyc_in   = clamp_row($signed({2'b00, oy_ff}) - $signed(Q_W'(r_eff)), h_eff);
               acc_v_in = '0;
               state_in = S_VSUM;
            end else if (c_ff == hi_ff) begin
               state_in = S_IDLE;
            end else begin
               c_in     = c_ff + COL_W'(1);
               acc_h_in = '0;
               state_in = S_HSUM;
            end
         end
         S_VSUM: begin
            mem_re = 1'b1;
            q_in   = qn;
            yyc_in = clamp_row(qn, h_eff);
            if (t_ff == last_tap) begin
               state_in = S_VWAIT;
            end else begin
               t_in = t_ff + 4'd1;
            end
         end
         S_VWAIT: begin
            if (!rd_v_ff && !prod_v_ff) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (res_ready) begin
               res_valid = 1'b1;
               if (drain_ff) begin
                  if (fe_ff) begin
                     in_row_in  = '0;
                     in_col_in  = '0;
                     out_row_in = '0;
                     out_col_in = '0;
                  end else if (re_ff) begin
                     out_col_in = '0;
                     out_row_in = out_row_ff + ROW_W'(1);
                  end else begin
                     out_col_in = out_col_ff + COL_W'(1);
                  end
                  state_in = S_IDLE;
               end else begin
                  if (rowend_ff && (c_ff == col_ff)) begin
                     out_col_in = '0;
                     out_row_in = oy_ff + ROW_W'(1);
                  end else begin
                     out_col_in = c_ff + COL_W'(1);
                  end
                  if (c_ff == hi_ff) begin
                     state_in = S_IDLE;
                  end else begin
                     c_in     = c_ff + COL_W'(1);
                     t_in     = '0;
                     acc_h_in = '0;
                     state_in = S_HSUM;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         win_ff     <= '0;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         rd_v_ff    <= 1'b0;
         prod_v_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         win_ff     <= win_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         rd_v_ff    <= mem_re;
         prod_v_ff  <= rd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      t_ff      <= t_in;
      acc_h_ff  <= acc_h_in;
      c_ff      <= c_in;
      hi_ff     <= hi_in;
      col_ff    <= col_in;
      emit_ff   <= emit_in;
      drain_ff  <= drain_in;
      rowend_ff <= rowend_in;
      re_ff     <= re_in;
      fe_ff     <= fe_in;
      oy_ff     <= oy_in;
      wslot_ff  <= wslot_in;
      q_ff      <= q_in;
      yyc_ff    <= yyc_in;
      acc_v_ff  <= acc_v_in;
      rd_ws_ff  <= ws_now;
      prod_ff   <= PROD_W'(mem_rdata) * PROD_W'(cfg.weight[rd_ws_ff]);
   end

   sgb_ram #(
      .WIDTH (HSUM_W),
      .DEPTH (STORE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   `SGB_ASSERT_IMPLY(a_tap_bound, clock, reset, (state_ff == S_HSUM) || (state_ff == S_VSUM), t_ff <= last_tap)
   `SGB_ASSERT_IMPLY(a_emit_drained, clock, reset, state_ff == S_EMIT, !rd_v_ff && !prod_v_ff)
   `SGB_ASSERT_IMPLY(a_push_room, clock, reset, res_valid, res_ready)
   `SGB_ASSERT_NEXT(a_write_after_taps, clock, reset, (state_ff == S_HSUM) && (t_ff == last_tap), state_ff == S_WRITE)

endmodule

[hdl/separable_gaussian_blur.sv]
// Separable blur with edge replication (see paragraph below): configuration
// registers, engine and output register. Depends on sgb_pkg, sgb_engine and sgb_out_buf.
`timescale 1ns / 1ps
// Pixels enter in raster order and blurred pixels leave in raster order, one item
// at a time. For every column whose horizontal sum becomes due, one 16x8
// multiplier walks the 2R+1 taps and the sum is written to the line store; for
// every result the 2R+1 stored sums are read through the single read port of
// the line store, weighted and rounded. R is the effective kernel radius; a
// pixel at the end of a row may release up to R+1 results. The line store needs
// no clearing after reset. Configuration must be written only while no item is
// in flight; the block itself does not enforce this. Weights are unsigned Q0.16.
module separable_gaussian_blur (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sgb_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sgb_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sgb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sgb_pkg::WT_W-1:0]         csr_wdata
);
   import sgb_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    res_valid, res_ready;
   rsp_type res_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:   cfg_in.frame_width   = csr_wdata[FW_W-1:0];
            CSR_FRAME_HEIGHT:  cfg_in.frame_height  = csr_wdata[ROW_W-1:0];
            CSR_KERNEL_RADIUS: cfg_in.kernel_radius = csr_wdata[RAD_W-1:0];
            CSR_WEIGHT_CENTER: cfg_in.weight[0]     = csr_wdata;
            CSR_WEIGHT_ONE:    cfg_in.weight[1]     = csr_wdata;
            CSR_WEIGHT_TWO:    cfg_in.weight[2]     = csr_wdata;
            CSR_WEIGHT_THREE:  cfg_in.weight[3]     = csr_wdata;
            CSR_WEIGHT_FOUR:   cfg_in.weight[4]     = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width   <= RST_FRAME_WIDTH;
         cfg_ff.frame_height  <= RST_FRAME_HEIGHT;
         cfg_ff.kernel_radius <= RST_RADIUS;
         cfg_ff.weight[0]     <= RST_WEIGHT_CENTER;
         cfg_ff.weight[1]     <= RST_WEIGHT_ONE;
         cfg_ff.weight[2]     <= '0;
         cfg_ff.weight[3]     <= '0;
         cfg_ff.weight[4]     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sgb_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   sgb_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res_data),
      .push_ready (res_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

[tb/separable_gaussian_blur_tb.sv]
// Self-checking testbench for the separable blur block with edge replication.
// Depends on sgb_pkg and separable_gaussian_blur; it predicts every result itself.
`timescale 1ns / 1ps
module separable_gaussian_blur_tb;
   import sgb_pkg::*;

   localparam int SETTLE_CYCLES = 150;
   localparam int ITEM_TARGET   = 340;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FRAME_WIDTH;
   logic [WT_W-1:0]      csr_wdata = '0;

   separable_gaussian_blur u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: configuration and the block's own storage.
   logic [FW_W-1:0]   cfg_width;
   logic [ROW_W-1:0]  cfg_height;
   logic [RAD_W-1:0]  cfg_radius;
   logic [WT_W-1:0]   cfg_weight [NUM_WEIGHTS];
   logic [HSUM_W-1:0] sum_rows [SLOTS*MAX_WIDTH];
   logic [PIX_W-1:0]  row_pix [WIN_DEPTH];
   int unsigned       next_in_col, next_in_row, next_out_col, next_out_row;
   bit                frame_closed;

   rsp_type     blurred_q[$];
   int unsigned error_count = 0;
   int unsigned burst_left = 0;
   int unsigned sent_items = 0;

   function automatic int unsigned eff_width();
      if (cfg_width < 1) return 1;
      if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
      return 32'(cfg_width);
   endfunction

   function automatic int unsigned eff_height();
      return (cfg_height < 1) ? 1 : 32'(cfg_height);
   endfunction

   function automatic int eff_radius();
      if (cfg_radius < 1) return 1;
      if (cfg_radius > RADIUS_CAP) return RADIUS_CAP;
      return int'(cfg_radius);
   endfunction

   function automatic logic [HSUM_W-1:0] row_sum(int col, int c, int r);
      longint unsigned acc;
      int p, k;
      acc = 0;
      for (int d = -r; d <= r; d++) begin
         p = c + d;
         if (p > col) p = col;
         k = col - p;
         if (k < 0) k = 0;
         if (k > 8) k = 8;
         acc += longint'(cfg_weight[d < 0 ? -d : d]) * row_pix[k];
      end
      if (acc > 64'hFFFFFF) acc = 64'hFFFFFF;
      return acc[HSUM_W-1:0];
   endfunction

   function automatic logic [PIX_W-1:0] column_sum(int oy, int unsigned x, int r, int h);
      longint unsigned acc;
      int yy;
      acc = 0;
      for (int d = -r; d <= r; d++) begin
         yy = oy + d;
         if (yy < 0) yy = 0;
         if (yy > h - 1) yy = h - 1;
         acc += longint'(sum_rows[(yy % SLOTS) * MAX_WIDTH + (x % MAX_WIDTH)])
                * cfg_weight[d < 0 ? -d : d];
      end
      acc = (acc + 64'h80000000) >> 32;
      if (acc > 255) acc = 255;
      return acc[PIX_W-1:0];
   endfunction

   function automatic void push_pixel(logic [PIX_W-1:0] pix, bit re, bit fe);
      rsp_type e;
      e.pixel_out = pix;
      e.row_end   = re;
      e.frame_end = fe;
      e.run_last  = 1'b0;
      blurred_q.push_back(e);
   endfunction

   function automatic void predict_blur(req_type it);
      int unsigned w, h;
      int r, n, col, lo, hi, oy;
      bit rowend, re, fe;
      rsp_type e;
      w = eff_width();
      h = eff_height();
      r = eff_radius();
      n = 0;
      if (it.mode == 1'b0) begin
         if (next_in_row >= h) return;
         col = next_in_col % MAX_WIDTH;
         if (col == 0) begin
            for (int k = 0; k < WIN_DEPTH; k++) row_pix[k] = it.pixel_in;
         end else begin
            for (int k = WIN_DEPTH - 1; k > 0; k--) row_pix[k] = row_pix[k-1];
            row_pix[0] = it.pixel_in;
         end
         rowend = (col + 1 >= w);
         if (rowend) begin
            lo = (col >= r) ? col - r : 0;
            hi = col;
         end else if (col >= r) begin
            lo = col - r;
            hi = col - r;
         end else begin
            lo = 0;
            hi = -1;
         end
         for (int c = lo; c <= hi; c++) begin
            sum_rows[(next_in_row % SLOTS) * MAX_WIDTH + c] = row_sum(col, c, r);
            if (next_in_row >= r) begin
               oy = next_in_row - r;
               re = rowend && c == col;
               push_pixel(column_sum(oy, c, r, h), re, 1'b0);
               n++;
               if (re) begin
                  next_out_col = 0;
                  next_out_row = oy + 1;
               end else begin
                  next_out_col = c + 1;
               end
            end
         end
         if (rowend) begin
            next_in_col = 0;
            next_in_row++;
         end else begin
            next_in_col = col + 1;
         end
      end else begin
         if (next_in_row < h) return;
         re = (next_out_col + 1 >= w);
         fe = re && (next_out_row + 1 >= h);
         push_pixel(column_sum(next_out_row, next_out_col, r, h), re, fe);
         n++;
         if (fe) begin
            next_in_row = 0;
            next_in_col = 0;
            next_out_row = 0;
            next_out_col = 0;
            frame_closed = 1'b1;
         end else if (re) begin
            next_out_col = 0;
            next_out_row++;
         end else begin
            next_out_col++;
         end
      end
      if (n > 0) begin
         e = blurred_q.pop_back();
         e.run_last = 1'b1;
         blurred_q.push_back(e);
      end
   endfunction

   // The receiver steps through four stall habits in turn.
   int unsigned stall_cycle = 0;
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         case ((stall_cycle / 400) % 4)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 0);
            2: rsp_stall <= (stall_cycle % 5 < 3);
            default: rsp_stall <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      rsp_type exp_px;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (blurred_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            error_count++;
         end else begin
            exp_px = blurred_q.pop_front();
            if (rsp_data.pixel_out !== exp_px.pixel_out) begin
               $display("%0t: pixel_out expected %0d actual %0d", $time,
                        exp_px.pixel_out, rsp_data.pixel_out);
               error_count++;
            end
            if (rsp_data.row_end !== exp_px.row_end) begin
               $display("%0t: row_end expected %b actual %b", $time,
                        exp_px.row_end, rsp_data.row_end);
               error_count++;
            end
            if (rsp_data.frame_end !== exp_px.frame_end) begin
               $display("%0t: frame_end expected %b actual %b", $time,
                        exp_px.frame_end, rsp_data.frame_end);
               error_count++;
            end
            if (rsp_data.run_last !== exp_px.run_last) begin
               $display("%0t: run_last expected %b actual %b", $time,
                        exp_px.run_last, rsp_data.run_last);
               error_count++;
            end
         end
      end
   end

   // Valid stays high between items of a burst; it drops only for a gap.
   task automatic send_item(input logic mode, input logic [PIX_W-1:0] pix);
      req_type it;
      it.mode = mode;
      it.pixel_in = pix;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      sent_items++;
      predict_blur(it);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (blurred_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WT_W-1:0] val,
                            input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (last) csr_valid <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH:   cfg_width  = val[FW_W-1:0];
         CSR_FRAME_HEIGHT:  cfg_height = val[ROW_W-1:0];
         CSR_KERNEL_RADIUS: cfg_radius = val[RAD_W-1:0];
         default:           cfg_weight[idx - CSR_WEIGHT_CENTER] = val;
      endcase
   endtask

   task automatic set_frame(input int w, input int h, input int r,
                            input logic [WT_W-1:0] wts [NUM_WEIGHTS]);
      write_reg(CSR_FRAME_WIDTH, WT_W'(w), 1'b0);
      write_reg(CSR_FRAME_HEIGHT, WT_W'(h), 1'b0);
      write_reg(CSR_KERNEL_RADIUS, WT_W'(r), 1'b0);
      write_reg(CSR_WEIGHT_CENTER, wts[0], 1'b0);
      write_reg(CSR_WEIGHT_ONE, wts[1], 1'b0);
      write_reg(CSR_WEIGHT_TWO, wts[2], 1'b0);
      write_reg(CSR_WEIGHT_THREE, wts[3], 1'b0);
      write_reg(CSR_WEIGHT_FOUR, wts[4], 1'b1);
   endtask

   // Drain ticks until the frame closes; stray pixels here must be dropped.
   task automatic drain_frame(input bit noisy);
      frame_closed = 1'b0;
      while (!frame_closed) begin
         if (noisy && $urandom_range(0, 9) == 0) begin
            send_item(1'b0, PIX_W'($urandom_range(0, 255)));
         end
         send_item(1'b1, PIX_W'($urandom_range(0, 255)));
      end
   endtask

   task automatic test_directed();
      logic [WT_W-1:0] wts [NUM_WEIGHTS];
      // Full-scale weights saturate both the row sums and the output.
      wts = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
      set_frame(3, 2, 0, wts);
      send_item(1'b0, 8'd255);
      send_item(1'b0, 8'd0);
      send_item(1'b1, 8'd0);    // drain tick while input is still due: no result
      send_item(1'b0, 8'd128);
      send_item(1'b0, 8'd1);
      send_item(1'b0, 8'd254);
      send_item(1'b0, 8'd0);
      send_item(1'b0, 8'd77);   // frame input complete: this pixel is dropped
      drain_frame(1'b0);
      wait_idle();
      // Zero width and height act as one, radius beyond the cap is clamped.
      wts = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
      set_frame(0, 0, 7, wts);
      send_item(1'b0, 8'd200);
      drain_frame(1'b0);
      wait_idle();
      wts = '{16'd32768, 16'd16384, 16'd0, 16'd0, 16'd0};
      set_frame(5, 3, 1, wts);
      for (int i = 0; i < 15; i++) send_item(1'b0, PIX_W'((i * 37) % 256));
      drain_frame(1'b0);
      wait_idle();
   endtask

   // Tallest height, then the height is cut to end the frame early.
   task automatic test_tall_frame();
      logic [WT_W-1:0] wts [NUM_WEIGHTS];
      wts = '{16'd20000, 16'd12000, 16'd9000, 16'd4000, 16'd1000};
      set_frame(4, 4095, 1, wts);
      for (int i = 0; i < 12; i++) send_item(1'b0, PIX_W'($urandom_range(0, 255)));
      wait_idle();
      write_reg(CSR_FRAME_HEIGHT, 16'd3, 1'b1);
      drain_frame(1'b0);
      wait_idle();
   endtask

   task automatic test_random_frames();
      logic [WT_W-1:0] wts [NUM_WEIGHTS];
      int w, h;
      while (sent_items < ITEM_TARGET) begin
         for (int i = 0; i < NUM_WEIGHTS; i++) begin
            case ($urandom_range(0, 5))
               0: wts[i] = 16'h0000;
               1: wts[i] = 16'hFFFF;
               default: wts[i] = WT_W'($urandom_range(0, 20000));
            endcase
         end
         w = $urandom_range(1, 12);
         h = $urandom_range(1, 8);
         set_frame(w, h, $urandom_range(0, 7), wts);
         for (int i = 0; i < w * h; i++) begin
            // A drain tick before the input is complete must give nothing.
            if ($urandom_range(0, 11) == 0) begin
               send_item(1'b1, PIX_W'($urandom_range(0, 255)));
            end
            send_item(1'b0, PIX_W'($urandom_range(0, 255)));
         end
         drain_frame(1'b1);
         wait_idle();
      end
   endtask

   initial begin
      cfg_width = RST_FRAME_WIDTH;
      cfg_height = RST_FRAME_HEIGHT;
      cfg_radius = RST_RADIUS;
      cfg_weight = '{RST_WEIGHT_CENTER, RST_WEIGHT_ONE, '0, '0, '0};
      for (int k = 0; k < WIN_DEPTH; k++) row_pix[k] = '0;
      next_in_col = 0;
      next_in_row = 0;
      next_out_col = 0;
      next_out_row = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_tall_frame();
      test_random_frames();
      wait_idle();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

[separable_gaussian_blur.f]
+incdir+hdl
hdl/sgb_pkg.sv
hdl/sgb_ram.sv
hdl/sgb_out_buf.sv
hdl/sgb_engine.sv
hdl/separable_gaussian_blur.sv
tb/separable_gaussian_blur_tb.sv
